### rtl/round_robin_job_scheduler_unit_macros.svh
// ----------------------------------------------------------------------------
// Round-robin job scheduler assertion macros
// Shared concurrent assertion forms for the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_JOB_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_JOB_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RRJS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRJS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/rrjs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin job scheduler package
// Sizes, record codes, register indexes and the types shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrjs_pkg;

   localparam int MAX_JOBS = 8;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);

   localparam int CLOCK_W  = 24;
   localparam int TIME_W   = 16;
   localparam int QUANT_W  = 8;

   // Record kinds
   localparam logic [1:0] KIND_IDLE = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_STOP = 2'd2;

   // Register indexes
   localparam logic CSR_QUANTUM    = 1'b0;
   localparam logic CSR_TIME_LIMIT = 1'b1;

   localparam logic [QUANT_W-1:0] QUANTUM_RESET    = 8'd2;
   localparam logic [TIME_W-1:0]  TIME_LIMIT_RESET = 16'd100;

   typedef struct packed {
      logic [15:0] arrival_time;
      logic [15:0] service_time;
      logic        last_job;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  job_index;
      logic [23:0] start_time;
      logic [23:0] end_time;
      logic        last_result;
   } rsp_data_type;

   typedef struct packed {
      logic load_write;   // accepted job beat
      logic admit_push;   // move next arrived job to queue tail
      logic idle_step;    // one idle time unit
      logic emit_idle;    // send the open idle run
      logic emit_stop;    // send the stop record
      logic serve_step;   // service turn, job stays
      logic serve_finish; // service turn, job leaves
      logic clear_batch;  // return pointers, counts and clock to zero
   } cmd_type;

   typedef struct packed {
      logic req_last;
      logic can_admit;
      logic queue_empty;
      logic all_admitted;
      logic idle_active;
      logic over_limit;
      logic finish_hit;
      logic finish_last;
      logic out_free;
   } status_type;

endpackage

### rtl/round_robin_job_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Round-robin job scheduler
// Loads a batch of jobs, then plays out round-robin service with a quantum.
//
//   channel   dir  handshake          payload
//   req_      in   valid / stall      rrjs_pkg::req_data_type (one job)
//   rsp_      out  valid / stall      rrjs_pkg::rsp_data_type (one record)
//   csr_      in   valid / ready      csr_index, csr_wdata
//
// Loading accepts one job beat per cycle. After the last job the controller
// steps the simulation: it admits each arrived job, counts idle time units
// while the queue is empty, sends each idle-run record and serves turns.
// Input is stalled for the whole simulation; an output stall holds the
// controller on the next record. Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_job_scheduler_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rrjs_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rrjs_pkg::rsp_data_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata
);

   rrjs_pkg::cmd_type    cmd;
   rrjs_pkg::status_type status;

   rrjs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrjs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### rtl/rrjs_datapath.sv
// ----------------------------------------------------------------------------
// Round-robin job scheduler datapath
// Job stores, ready queue, pointers, clock, config registers and result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_job_scheduler_unit_macros.svh"

module rrjs_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  rrjs_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rrjs_pkg::rsp_data_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [15:0]           csr_wdata,
   input  rrjs_pkg::cmd_type     cmd,
   output rrjs_pkg::status_type  status
);

   localparam int IW = rrjs_pkg::IDX_W;
   localparam int CW = rrjs_pkg::CNT_W;
   localparam int NJ = rrjs_pkg::MAX_JOBS;

   logic [rrjs_pkg::TIME_W-1:0]  arrivals_ff  [NJ];
   logic [rrjs_pkg::TIME_W-1:0]  arrivals_in  [NJ];
   logic [rrjs_pkg::TIME_W-1:0]  remaining_ff [NJ];
   logic [rrjs_pkg::TIME_W-1:0]  remaining_in [NJ];
   logic [IW-1:0]                queue_ff     [NJ];
   logic [IW-1:0]                queue_in     [NJ];

   logic [CW-1:0]                qlen_ff, qlen_in;
   logic [CW-1:0]                loaded_ff, loaded_in;
   logic [CW-1:0]                admit_ff, admit_in;
   logic [IW-1:0]                sp_ff, sp_in;
   logic [rrjs_pkg::CLOCK_W-1:0] clock_ff, clock_in;
   logic                         idle_ff, idle_in;
   logic [rrjs_pkg::CLOCK_W-1:0] idle_start_ff, idle_start_in;
   logic [rrjs_pkg::QUANT_W-1:0] quantum_ff, quantum_in;
   logic [rrjs_pkg::TIME_W-1:0]  limit_ff, limit_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rrjs_pkg::rsp_data_type       rsp_data_ff, rsp_data_in;

   logic [IW-1:0]                admit_idx;
   logic [IW-1:0]                spx;
   logic [IW-1:0]                job;
   logic [rrjs_pkg::QUANT_W-1:0] q_eff;
   logic [rrjs_pkg::CLOCK_W-1:0] clock_serve;
   logic [rrjs_pkg::CLOCK_W-1:0] clock_next_idle;
   logic                         out_free;
   logic                         out_load;

   assign admit_idx       = admit_ff[IW-1:0];
   assign spx             = ({1'b0, sp_ff} >= (IW+1)'(qlen_ff)) ? '0 : sp_ff;
   assign job             = queue_ff[spx];
   assign q_eff           = (quantum_ff == '0) ? rrjs_pkg::QUANT_W'(1) : quantum_ff;
   assign clock_serve     = clock_ff + rrjs_pkg::CLOCK_W'(q_eff);
   assign clock_next_idle = clock_ff + rrjs_pkg::CLOCK_W'(1);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign out_load        = cmd.emit_idle || cmd.emit_stop || cmd.serve_finish;

   assign status.req_last     = req_data.last_job;
   assign status.can_admit    = (admit_ff < loaded_ff) && (qlen_ff < CW'(NJ)) &&
                                (rrjs_pkg::CLOCK_W'(arrivals_ff[admit_idx]) <= clock_ff);
   assign status.queue_empty  = (qlen_ff == '0);
   assign status.all_admitted = (admit_ff == loaded_ff);
   assign status.idle_active  = idle_ff;
   assign status.over_limit   = clock_next_idle > rrjs_pkg::CLOCK_W'(limit_ff);
   assign status.finish_hit   = remaining_ff[job] <= rrjs_pkg::TIME_W'(q_eff);
   assign status.finish_last  = (qlen_ff == CW'(1)) && (admit_ff == loaded_ff);
   assign status.out_free     = out_free;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      arrivals_in   = arrivals_ff;
      remaining_in  = remaining_ff;
      queue_in      = queue_ff;
      qlen_in       = qlen_ff;
      loaded_in     = loaded_ff;
      admit_in      = admit_ff;
      sp_in         = sp_ff;
      clock_in      = clock_ff;
      idle_in       = idle_ff;
      idle_start_in = idle_start_ff;
      quantum_in    = quantum_ff;
      limit_in      = limit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_valid) begin
         unique case (csr_index)
            rrjs_pkg::CSR_QUANTUM:    quantum_in = csr_wdata[rrjs_pkg::QUANT_W-1:0];
            rrjs_pkg::CSR_TIME_LIMIT: limit_in   = csr_wdata;
            default:                  limit_in   = limit_ff;
         endcase
      end

      // Drop jobs beyond the batch capacity.
      if (cmd.load_write && (loaded_ff < CW'(NJ))) begin
         arrivals_in[loaded_ff[IW-1:0]]  = req_data.arrival_time;
         remaining_in[loaded_ff[IW-1:0]] = req_data.service_time;
         loaded_in                       = loaded_ff + CW'(1);
      end

      if (cmd.admit_push) begin
         queue_in[qlen_ff[IW-1:0]] = admit_idx;
         qlen_in                   = qlen_ff + CW'(1);
         admit_in                  = admit_ff + CW'(1);
      end

      if (cmd.idle_step) begin
         if (!idle_ff) begin
            idle_start_in = clock_ff;
         end
         idle_in  = 1'b1;
         clock_in = clock_next_idle;
      end

      if (cmd.serve_step) begin
         remaining_in[job] = remaining_ff[job] - rrjs_pkg::TIME_W'(q_eff);
         sp_in             = spx + IW'(1);
         clock_in          = clock_serve;
      end

      // Close the gap left by the finished job; the pointer stays put.
      if (cmd.serve_finish) begin
         for (int k = 0; k < NJ - 1; k++) begin
            if (k >= int'(spx)) begin
               queue_in[k] = queue_ff[k + 1];
            end
         end
         qlen_in  = qlen_ff - CW'(1);
         sp_in    = spx;
         clock_in = clock_serve;
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         priority if (cmd.serve_finish) begin
            rsp_data_in.kind        = rrjs_pkg::KIND_DONE;
            rsp_data_in.job_index   = 4'(job);
            rsp_data_in.start_time  = '0;
            rsp_data_in.end_time    = clock_serve;
            rsp_data_in.last_result = status.finish_last;
         end else if (cmd.emit_stop) begin
            rsp_data_in.kind        = rrjs_pkg::KIND_STOP;
            rsp_data_in.job_index   = '0;
            rsp_data_in.start_time  = '0;
            rsp_data_in.end_time    = clock_ff;
            rsp_data_in.last_result = 1'b1;
         end else begin
            rsp_data_in.kind        = rrjs_pkg::KIND_IDLE;
            rsp_data_in.job_index   = '0;
            rsp_data_in.start_time  = idle_start_ff;
            rsp_data_in.end_time    = clock_ff;
            rsp_data_in.last_result = 1'b0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit_idle) begin
         idle_in = 1'b0;
      end

      if (cmd.clear_batch) begin
         qlen_in   = '0;
         loaded_in = '0;
         admit_in  = '0;
         sp_in     = '0;
         clock_in  = '0;
         idle_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlen_ff      <= '0;
         loaded_ff    <= '0;
         admit_ff     <= '0;
         sp_ff        <= '0;
         clock_ff     <= '0;
         idle_ff      <= 1'b0;
         quantum_ff   <= rrjs_pkg::QUANTUM_RESET;
         limit_ff     <= rrjs_pkg::TIME_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         qlen_ff      <= qlen_in;
         loaded_ff    <= loaded_in;
         admit_ff     <= admit_in;
         sp_ff        <= sp_in;
         clock_ff     <= clock_in;
         idle_ff      <= idle_in;
         quantum_ff   <= quantum_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      arrivals_ff   <= arrivals_in;
      remaining_ff  <= remaining_in;
      queue_ff      <= queue_in;
      idle_start_ff <= idle_start_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `RRJS_ASSERT_IMPL(a_emit_needs_slot, clock, reset, out_load, out_free, "record emitted into a busy output")
   `RRJS_ASSERT_IMPL(a_queue_within_admitted, clock, reset, 1'b1, qlen_ff <= admit_ff, "queue longer than admitted jobs")
   `RRJS_ASSERT_IMPL(a_admit_within_loaded, clock, reset, 1'b1, admit_ff <= loaded_ff, "admit pointer past loaded jobs")
   `RRJS_ASSERT_NEXT(a_stop_clears_clock, clock, reset, cmd.emit_stop, clock_ff == '0 && qlen_ff == '0, "batch not cleared after stop")

endmodule

### rtl/rrjs_ctrl.sv
// ----------------------------------------------------------------------------
// Round-robin job scheduler controller
// Sequences loading, admission, idle counting, service turns and record beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrjs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rrjs_pkg::status_type status,
   output rrjs_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_LOAD      = 7'b0000001,
      S_ADMIT     = 7'b0000010,
      S_CHOOSE    = 7'b0000100,
      S_EMIT_IDLE = 7'b0001000,
      S_IDLE_STOP = 7'b0010000,
      S_EMIT_STOP = 7'b0100000,
      S_SERVE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               cmd.load_write = 1'b1;
               if (status.req_last) begin
                  state_in = S_ADMIT;
               end
            end
         end
         S_ADMIT: begin
            if (status.can_admit) begin
               cmd.admit_push = 1'b1;
            end else begin
               state_in = S_CHOOSE;
            end
         end
         S_CHOOSE: begin
            priority if (status.queue_empty && status.all_admitted) begin
               cmd.clear_batch = 1'b1;
               state_in        = S_LOAD;
            end else if (status.queue_empty) begin
               cmd.idle_step = 1'b1;
               state_in      = status.over_limit ? S_IDLE_STOP : S_ADMIT;
            end else if (status.idle_active) begin
               state_in = S_EMIT_IDLE;
            end else begin
               state_in = S_SERVE;
            end
         end
         S_EMIT_IDLE: begin
            if (status.out_free) begin
               cmd.emit_idle = 1'b1;
               state_in      = S_SERVE;
            end
         end
         S_IDLE_STOP: begin
            if (status.out_free) begin
               cmd.emit_idle = 1'b1;
               state_in      = S_EMIT_STOP;
            end
         end
         S_EMIT_STOP: begin
            if (status.out_free) begin
               cmd.emit_stop   = 1'b1;
               cmd.clear_batch = 1'b1;
               state_in        = S_LOAD;
            end
         end
         S_SERVE: begin
            // Hold a finishing turn until the output register frees up.
            if (!status.finish_hit) begin
               cmd.serve_step = 1'b1;
               state_in       = S_ADMIT;
            end else if (status.out_free) begin
               cmd.serve_finish = 1'b1;
               if (status.finish_last) begin
                  cmd.clear_batch = 1'b1;
                  state_in        = S_LOAD;
               end else begin
                  state_in = S_ADMIT;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
